[src/s2x_pkg.sv]
// shared types, constants and the corner rule for the 2x pixel upscaler
`default_nettype none

package s2x_pkg;

    // geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int PIX_W      = 24;

    // configuration registers
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;
    localparam logic [CFG_WIDTH_W-1:0]  CFG_WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_HEIGHT_W-1:0] CFG_HEIGHT_RESET = 13'd768;

    // compare domains wide enough for both the register and the limit
    localparam int EW_W = (CFG_WIDTH_W > COL_W + 1) ? CFG_WIDTH_W : COL_W + 1;
    localparam int EH_W = (CFG_HEIGHT_W > ROW_W + 1) ? CFG_HEIGHT_W : ROW_W + 1;
    localparam logic [EW_W-1:0] MAX_W_VAL = EW_W'(MAX_WIDTH);
    localparam logic [EH_W-1:0] MAX_H_VAL = EH_W'(MAX_HEIGHT);

    // job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [PIX_W-1:0] t_pix;

    // which blocks a source pixel releases, and the clamp conditions
    typedef struct packed {
        logic emit_up;      // block of the row above, also row >= 1
        logic emit_left;    // last row: block to the left
        logic emit_corner;  // last row, last column: own block, end of frame
        logic col_ge1;
        logic col_ge2;
        logic rgt_ok;       // column + 1 lies inside the row
        logic row_ge2;
    } t_flags;

    // one classified source pixel with every neighbour it needs
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        t_flags           flags;
        t_pix             ctr;   // row above, this column
        t_pix             top;   // two rows above, this column
        t_pix             rgt;   // row above, next column
        t_pix             pix;   // incoming pixel
        t_pix             ctr1;  // row above, previous column
        t_pix             pix1;  // previous pixel of this row
        t_pix             pix2;  // pixel before that
    } t_job;

    typedef struct packed {
        logic stage_valid;
        logic push;
    } t_front_stat;

    typedef struct packed {
        t_pix tl;
        t_pix tr;
        t_pix bl;
        t_pix br;
    } t_quad;

    // corner rule on exact colour equality
    function automatic t_quad scale2x(input t_pix c, input t_pix t, input t_pix l,
                                      input t_pix r, input t_pix b);
        t_quad q;
        q.tl = c;
        q.tr = c;
        q.bl = c;
        q.br = c;
        if (l != r && t != b) begin
            if (t == l) q.tl = t;
            if (t == r) q.tr = t;
            if (b == l) q.bl = b;
            if (b == r) q.br = b;
        end
        return q;
    endfunction

endpackage

`default_nettype wire

[src/scale2x_pixel_upscaler.sv]
// top level of the streaming 2x pixel upscaler
`default_nettype none

// Takes RGB888 source pixels in raster order, one per clock unless o_in_stall
// holds them, and emits one 2x2 output block per clock from a registered
// output unless i_out_stall holds it. A block leaves once its lower and right
// neighbours have arrived: pixel (x, y) with y >= 1 releases block (x, y-1).
// On the last row each pixel also releases the block to its left, if it has
// one, and the final pixel of the frame its own block as well, and there the
// single output register sets the pace. On an input transfer the line stores
// are read into the fetch stage, the job is then written into the job queue
// and the output register is then loaded from the queue head. Two line stores
// of MAX_WIDTH entries each hold the previous rows and need no clearing after
// reset. Width and height are taken from the configuration port, clamped to
// 1..MAX_WIDTH and 1..4096, and should be written between frames while no
// block is pending.
module scale2x_pixel_upscaler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [s2x_pkg::PIX_W-1:0]     i_pixel,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [s2x_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [s2x_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [s2x_pkg::COL_W-1:0]     o_block_x,
    output logic [s2x_pkg::ROW_W-1:0]     o_block_y,
    output logic [s2x_pkg::PIX_W-1:0]     o_top_left,
    output logic [s2x_pkg::PIX_W-1:0]     o_top_right,
    output logic [s2x_pkg::PIX_W-1:0]     o_bottom_left,
    output logic [s2x_pkg::PIX_W-1:0]     o_bottom_right,
    output logic                          o_frame_end
);
    import s2x_pkg::*;

    t_job              job;
    t_front_stat       front_stat;
    t_job              head;
    logic              head_valid;
    logic              q_pop;
    logic [QCNT_W-1:0] q_count;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    s2x_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_pixel     (i_pixel),
        .i_q_count   (q_count),
        .o_job       (job),
        .o_stat      (front_stat)
    );

    s2x_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (front_stat.push),
        .i_push_job   (job),
        .i_pop        (q_pop),
        .o_head       (head),
        .o_head_valid (head_valid),
        .o_count      (q_count)
    );

    s2x_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_head_valid   (head_valid),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_block_x      (o_block_x),
        .o_block_y      (o_block_y),
        .o_top_left     (o_top_left),
        .o_top_right    (o_top_right),
        .o_bottom_left  (o_bottom_left),
        .o_bottom_right (o_bottom_right),
        .o_frame_end    (o_frame_end)
    );

    // a pixel in the fetch stage always has a queue slot reserved
    a_slot_reserved : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_stat.stage_valid |-> (q_count < QCNT_W'(QUEUE_DEPTH)))
        else $error("fetch stage holds a pixel without a free queue slot");

    // the back end only retires a job that is present
    a_pop_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (q_count != '0))
        else $error("job retired from an empty queue");

    // the final block has its right and bottom neighbours clamped to itself
    a_frame_end_corners : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |->
            (o_top_right == o_bottom_right && o_bottom_left == o_bottom_right))
        else $error("frame end block has inconsistent clamped corners");

endmodule

`default_nettype wire

[src/s2x_queue.sv]
// short job queue that decouples pixel classification from block output
`default_nettype none

module s2x_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  s2x_pkg::t_job            i_push_job,
    input  logic                     i_pop,
    output s2x_pkg::t_job            o_head,
    output logic                     o_head_valid,
    output logic [s2x_pkg::QCNT_W-1:0] o_count
);
    import s2x_pkg::*;

    t_job              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;

    // pointer wrap for any depth
    always_comb begin
        if (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) n_wr_ptr = '0;
        else n_wr_ptr = r_wr_ptr + QPTR_W'(1);
        if (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) n_rd_ptr = '0;
        else n_rd_ptr = r_rd_ptr + QPTR_W'(1);
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= n_wr_ptr;
            if (i_pop) r_rd_ptr <= n_rd_ptr;
            if (i_push && !i_pop) r_count <= r_count + QCNT_W'(1);
            else if (!i_push && i_pop) r_count <= r_count - QCNT_W'(1);
        end
    end

    // job storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr_ptr] <= i_push_job;
    end

    assign o_head       = r_slot[r_rd_ptr];
    assign o_head_valid = (r_count != '0);
    assign o_count      = r_count;

endmodule

`default_nettype wire

[src/s2x_front.sv]
// front end: raster cursor, line stores, neighbour fetch and job building
`default_nettype none

module s2x_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [s2x_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [s2x_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [s2x_pkg::PIX_W-1:0]     i_pixel,
    input  logic [s2x_pkg::QCNT_W-1:0]    i_q_count,
    output s2x_pkg::t_job                 o_job,
    output s2x_pkg::t_front_stat          o_stat
);
    import s2x_pkg::*;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        t_flags           flags;
        t_pix             pix;
    } t_stage;

    // configuration and cursor
    logic [CFG_WIDTH_W-1:0]  r_cfg_width;
    logic [CFG_HEIGHT_W-1:0] r_cfg_height;
    logic [COL_W-1:0]        r_col;
    logic [ROW_W-1:0]        r_row;
    logic [COL_W-1:0]        n_col;
    logic [ROW_W-1:0]        n_row;

    // line stores: upper holds the older of the two rows
    t_pix r_cur_mem [MAX_WIDTH];
    t_pix r_up_mem  [MAX_WIDTH];
    t_pix r_rd_ctr;
    t_pix r_rd_rgt;
    t_pix r_rd_top;
    logic r_fwd;
    t_pix r_fwd_data;

    // fetch stage and pixel history
    logic   r_e_valid;
    t_stage r_e;
    t_stage n_e;
    t_pix   r_h_ctr1;
    t_pix   r_h_p1;
    t_pix   r_h_p2;

    logic [EW_W-1:0]   w_raw;
    logic [EW_W-1:0]   eff_w;
    logic [EH_W-1:0]   h_raw;
    logic [EH_W-1:0]   eff_h;
    logic              wrap0;
    logic [EH_W-1:0]   row_pre;
    logic [EH_W-1:0]   row_cur_ext;
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [EW_W-1:0]   col_inc;
    logic [EH_W-1:0]   row_inc;
    logic              end_row;
    logic              last_row;
    logic [COL_W-1:0]  rgt_addr;
    logic [QCNT_W:0]   occupied;
    logic              acc;
    t_pix              e_ctr;
    t_pix              e_top;
    logic              up_we;

    // room for this pixel and the one already in the fetch stage
    assign occupied   = {1'b0, i_q_count} + (QCNT_W + 1)'(r_e_valid);
    assign o_in_stall = (occupied >= (QCNT_W + 1)'(QUEUE_DEPTH));
    assign acc        = i_in_valid && !o_in_stall;

    // effective frame size
    always_comb begin
        w_raw = EW_W'(r_cfg_width);
        h_raw = EH_W'(r_cfg_height);
        if (w_raw == '0) eff_w = EW_W'(1);
        else if (w_raw > MAX_W_VAL) eff_w = MAX_W_VAL;
        else eff_w = w_raw;
        if (h_raw == '0) eff_h = EH_W'(1);
        else if (h_raw > MAX_H_VAL) eff_h = MAX_H_VAL;
        else eff_h = h_raw;
    end

    // cursor position, classification and next cursor
    always_comb begin
        wrap0       = (EW_W'(r_col) >= eff_w);
        row_pre     = wrap0 ? (EH_W'(r_row) + EH_W'(1)) : EH_W'(r_row);
        row_cur_ext = (row_pre >= eff_h) ? '0 : row_pre;
        cur_row     = row_cur_ext[ROW_W-1:0];
        cur_col     = wrap0 ? '0 : r_col;
        col_inc     = EW_W'(cur_col) + EW_W'(1);
        row_inc     = EH_W'(cur_row) + EH_W'(1);
        end_row     = (col_inc >= eff_w);
        last_row    = (EH_W'(cur_row) == eff_h - EH_W'(1));
        rgt_addr    = col_inc[COL_W-1:0];

        if (end_row) begin
            n_col = '0;
            n_row = (row_inc >= eff_h) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            n_col = col_inc[COL_W-1:0];
            n_row = cur_row;
        end

        n_e.col               = cur_col;
        n_e.row               = cur_row;
        n_e.pix               = i_pixel;
        n_e.flags.emit_up     = (cur_row != '0);
        n_e.flags.col_ge1     = (cur_col != '0);
        n_e.flags.col_ge2     = (EW_W'(cur_col) >= EW_W'(2));
        n_e.flags.emit_left   = last_row && (cur_col != '0);
        n_e.flags.emit_corner = last_row && (col_inc == eff_w);
        n_e.flags.rgt_ok      = (col_inc < eff_w);
        n_e.flags.row_ge2     = (EH_W'(cur_row) >= EH_W'(2));
    end

    // configuration, cursor and stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= CFG_WIDTH_RESET;
            r_cfg_height <= CFG_HEIGHT_RESET;
            r_col        <= '0;
            r_row        <= '0;
            r_e_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IDX_WIDTH:  r_cfg_width  <= i_cfg_data[CFG_WIDTH_W-1:0];
                    CFG_IDX_HEIGHT: r_cfg_height <= i_cfg_data[CFG_HEIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            r_e_valid <= acc;
        end
    end

    // upper store is written from the fetch stage, so a same-column read at that edge is forwarded
    assign e_ctr = r_rd_ctr;
    assign e_top = r_fwd ? r_fwd_data : r_rd_top;
    assign up_we = r_e_valid && r_e.flags.emit_up;

    // line stores and neighbour fetch
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_cur_mem[cur_col] <= i_pixel;
            r_rd_ctr           <= r_cur_mem[cur_col];
            r_rd_rgt           <= r_cur_mem[rgt_addr];
            r_rd_top           <= r_up_mem[cur_col];
            r_e                <= n_e;
        end
        if (up_we) r_up_mem[r_e.col] <= e_ctr;
        r_fwd      <= acc && up_we && (r_e.col == cur_col);
        r_fwd_data <= e_ctr;
    end

    // history of the previous two pixels of the row
    always_ff @(posedge i_clk) begin
        if (r_e_valid) begin
            r_h_ctr1 <= e_ctr;
            r_h_p1   <= r_e.pix;
            r_h_p2   <= r_h_p1;
        end
    end

    // job for the queue
    always_comb begin
        o_job.col   = r_e.col;
        o_job.row   = r_e.row;
        o_job.flags = r_e.flags;
        o_job.ctr   = e_ctr;
        o_job.top   = e_top;
        o_job.rgt   = r_rd_rgt;
        o_job.pix   = r_e.pix;
        o_job.ctr1  = r_h_ctr1;
        o_job.pix1  = r_h_p1;
        o_job.pix2  = r_h_p2;
    end

    assign o_stat.stage_valid = r_e_valid;
    assign o_stat.push        = r_e_valid && (r_e.flags.emit_up || r_e.flags.emit_left ||
                                              r_e.flags.emit_corner);

endmodule

`default_nettype wire

[src/s2x_back.sv]
// back end: walks the blocks of each job and drives the output register
`default_nettype none

module s2x_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  s2x_pkg::t_job              i_head,
    input  logic                       i_head_valid,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [s2x_pkg::COL_W-1:0]  o_block_x,
    output logic [s2x_pkg::ROW_W-1:0]  o_block_y,
    output logic [s2x_pkg::PIX_W-1:0]  o_top_left,
    output logic [s2x_pkg::PIX_W-1:0]  o_top_right,
    output logic [s2x_pkg::PIX_W-1:0]  o_bottom_left,
    output logic [s2x_pkg::PIX_W-1:0]  o_bottom_right,
    output logic                       o_frame_end
);
    import s2x_pkg::*;

    logic [2:0]       r_done;
    logic [2:0]       n_done;
    logic             r_valid;
    logic [COL_W-1:0] r_x;
    logic [ROW_W-1:0] r_y;
    t_quad            r_quad;
    logic             r_fend;

    logic [2:0]       emit;
    logic [2:0]       rem;
    logic [2:0]       pick;
    logic             can_load;
    logic             load;
    t_pix             nc, nt, nl, nr, nb;
    logic [COL_W-1:0] sel_x;
    logic [ROW_W-1:0] sel_y;
    logic             sel_fend;
    t_quad            quad;

    // choose the next block of the head job: upper, then left, then corner
    always_comb begin
        emit     = {i_head.flags.emit_corner, i_head.flags.emit_left, i_head.flags.emit_up};
        rem      = emit & ~r_done;
        can_load = !r_valid || !i_out_stall;
        load     = can_load && i_head_valid && (rem != 3'b000);
        if (rem[0]) pick = 3'b001;
        else if (rem[1]) pick = 3'b010;
        else pick = 3'b100;
        o_pop    = load && ((rem & ~pick) == 3'b000);
        if (o_pop) n_done = 3'b000;
        else if (load) n_done = r_done | pick;
        else n_done = r_done;
    end

    // neighbour selection with edge clamping
    always_comb begin
        if (rem[0]) begin
            nc       = i_head.ctr;
            nt       = i_head.flags.row_ge2 ? i_head.top : i_head.ctr;
            nl       = i_head.flags.col_ge1 ? i_head.ctr1 : i_head.ctr;
            nr       = i_head.flags.rgt_ok ? i_head.rgt : i_head.ctr;
            nb       = i_head.pix;
            sel_x    = i_head.col;
            sel_y    = i_head.row - ROW_W'(1);
            sel_fend = 1'b0;
        end else if (rem[1]) begin
            nc       = i_head.pix1;
            nt       = i_head.flags.emit_up ? i_head.ctr1 : i_head.pix1;
            nl       = i_head.flags.col_ge2 ? i_head.pix2 : i_head.pix1;
            nr       = i_head.pix;
            nb       = i_head.pix1;
            sel_x    = i_head.col - COL_W'(1);
            sel_y    = i_head.row;
            sel_fend = 1'b0;
        end else begin
            nc       = i_head.pix;
            nt       = i_head.flags.emit_up ? i_head.ctr : i_head.pix;
            nl       = i_head.flags.col_ge1 ? i_head.pix1 : i_head.pix;
            nr       = i_head.pix;
            nb       = i_head.pix;
            sel_x    = i_head.col;
            sel_y    = i_head.row;
            sel_fend = 1'b1;
        end
        quad = scale2x(nc, nt, nl, nr, nb);
    end

    // sequencing state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 3'b000;
            r_valid <= 1'b0;
        end else begin
            r_done <= n_done;
            if (can_load) r_valid <= load;
        end
        if (load) begin
            r_x    <= sel_x;
            r_y    <= sel_y;
            r_quad <= quad;
            r_fend <= sel_fend;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_block_x      = r_x;
    assign o_block_y      = r_y;
    assign o_top_left     = r_quad.tl;
    assign o_top_right    = r_quad.tr;
    assign o_bottom_left  = r_quad.bl;
    assign o_bottom_right = r_quad.br;
    assign o_frame_end    = r_fend;

endmodule

`default_nettype wire

[dv/tb_scale2x_pixel_upscaler.sv]
// self-checking testbench for the streaming scale2x pixel upscaler
`timescale 1ns / 1ps

module tb_scale2x_pixel_upscaler;
    import s2x_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int QUIET_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 200;

    localparam t_pix COL_BLACK = 24'h000000;
    localparam t_pix COL_WHITE = 24'hFFFFFF;
    localparam t_pix COL_MID   = 24'h123456;
    localparam t_pix COL_ALT   = 24'hA5A5A5;

    // 3x3 frame: centre has distinct left/right and top/bottom
    localparam t_pix FRAME_3X3 [9] = '{
        COL_BLACK, COL_BLACK, COL_WHITE,
        COL_BLACK, COL_MID,   COL_WHITE,
        COL_MID,   COL_WHITE, COL_WHITE
    };
    // 4x2 frame: only two rows, so every block is released by a pixel of the last row
    localparam t_pix FRAME_4X2 [8] = '{
        COL_WHITE, COL_WHITE, COL_ALT,   COL_BLACK,
        COL_BLACK, COL_WHITE, COL_ALT,   COL_ALT
    };

    typedef struct packed {
        logic [COL_W-1:0] x;
        logic [ROW_W-1:0] y;
        t_pix             tl;
        t_pix             tr;
        t_pix             bl;
        t_pix             br;
        logic             fend;
    } t_block;

    // predicts the 2x2 blocks released by each source pixel and checks them
    class scale2x_scoreboard;
        t_pix        upper_row [MAX_WIDTH];
        t_pix        cur_row [MAX_WIDTH];
        int unsigned col;
        int unsigned row;
        int unsigned width_reg;
        int unsigned height_reg;
        t_block      pending_blocks [$];
        int unsigned mismatches;

        function new();
            foreach (upper_row[i]) begin
                upper_row[i] = '0;
                cur_row[i]   = '0;
            end
            col        = 0;
            row        = 0;
            width_reg  = CFG_WIDTH_RESET;
            height_reg = CFG_HEIGHT_RESET;
            mismatches = 0;
        endfunction

        function int unsigned eff_width();
            if (width_reg < 1) return 1;
            if (width_reg > MAX_WIDTH) return MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            if (height_reg < 1) return 1;
            if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
            return height_reg;
        endfunction

        function int unsigned frame_size();
            return eff_width() * eff_height();
        endfunction

        function int unsigned pending();
            return pending_blocks.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_IDX_WIDTH) width_reg = data[CFG_WIDTH_W-1:0];
            else height_reg = data[CFG_HEIGHT_W-1:0];
        endfunction

        // corner rule on exact equality, then queue the block
        function void queue_block(int unsigned x, int unsigned y, t_pix c, t_pix t,
                                  t_pix l, t_pix r, t_pix b, logic fend);
            t_block blk;
            blk.x    = x[COL_W-1:0];
            blk.y    = y[ROW_W-1:0];
            blk.tl   = c;
            blk.tr   = c;
            blk.bl   = c;
            blk.br   = c;
            blk.fend = fend;
            if (l != r && t != b) begin
                if (t == l) blk.tl = t;
                if (t == r) blk.tr = t;
                if (b == l) blk.bl = b;
                if (b == r) blk.br = b;
            end
            pending_blocks.push_back(blk);
        endfunction

        function void take_pixel(t_pix p);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            t_pix        ctr;
            t_pix        top;
            t_pix        lft;
            t_pix        rgt;
            w = eff_width();
            h = eff_height();
            if (col >= w) begin
                col = 0;
                row++;
            end
            if (row >= h) row = 0;
            c = col;
            r = row;
            // block of the row above is now complete
            if (r >= 1) begin
                ctr = cur_row[c];
                top = (r >= 2) ? upper_row[c] : ctr;
                lft = (c >= 1) ? upper_row[c-1] : ctr;
                rgt = (c + 1 < w) ? cur_row[c+1] : ctr;
                queue_block(c, r - 1, ctr, top, lft, rgt, p, 1'b0);
                upper_row[c] = ctr;
            end
            cur_row[c] = p;
            // last row: blocks to the left and the final corner
            if (r == h - 1) begin
                if (c >= 1) begin
                    ctr = cur_row[c-1];
                    lft = (c >= 2) ? cur_row[c-2] : ctr;
                    top = (r >= 1) ? upper_row[c-1] : ctr;
                    queue_block(c - 1, r, ctr, top, lft, p, ctr, 1'b0);
                end
                if (c == w - 1) begin
                    lft = (c >= 1) ? cur_row[c-1] : p;
                    top = (r >= 1) ? upper_row[c] : p;
                    queue_block(c, r, p, top, lft, p, p, 1'b1);
                end
            end
            col = c + 1;
            if (col >= w) begin
                col = 0;
                row = r + 1;
                if (row >= h) row = 0;
            end
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_block(t_block got);
            t_block want;
            if (pending_blocks.size() == 0) begin
                $error("block (%0d, %0d) with no block expected", got.x, got.y);
                mismatches++;
                return;
            end
            want = pending_blocks.pop_front();
            compare("block_x", want.x, got.x);
            compare("block_y", want.y, got.y);
            compare("top_left", want.tl, got.tl);
            compare("top_right", want.tr, got.tr);
            compare("bottom_left", want.bl, got.bl);
            compare("bottom_right", want.br, got.br);
            compare("frame_end", want.fend, got.fend);
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  pix_valid = 1'b0;
    t_pix                  pix_data  = '0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_IDX_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  out_stall = 1'b0;

    logic                  o_in_stall;
    logic                  o_cfg_ready;
    logic                  o_out_valid;
    logic [COL_W-1:0]      o_block_x;
    logic [ROW_W-1:0]      o_block_y;
    t_pix                  o_top_left;
    t_pix                  o_top_right;
    t_pix                  o_bottom_left;
    t_pix                  o_bottom_right;
    logic                  o_frame_end;

    scale2x_scoreboard sb;
    int unsigned       send_idle_pct  = 0;
    int unsigned       recv_stall_pct = 0;
    int unsigned       quiet_cycles   = 0;
    bit                any_transfer;
    t_block            seen;

    scale2x_pixel_upscaler DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (pix_valid),
        .o_in_stall     (o_in_stall),
        .i_pixel        (pix_data),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_block_x      (o_block_x),
        .o_block_y      (o_block_y),
        .o_top_left     (o_top_left),
        .o_top_right    (o_top_right),
        .o_bottom_left  (o_bottom_left),
        .o_bottom_right (o_bottom_right),
        .o_frame_end    (o_frame_end)
    );

    always #4 clk = ~clk;

    // random back-pressure on the result side
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // monitor: every transfer goes to the scoreboard; watchdog on quiet cycles
    always @(posedge clk) begin
        if (rst_n) begin
            any_transfer = 1'b0;
            if (pix_valid && !o_in_stall) begin
                sb.take_pixel(pix_data);
                any_transfer = 1'b1;
            end
            if (cfg_valid && o_cfg_ready) begin
                sb.write_reg(cfg_index, cfg_data);
                any_transfer = 1'b1;
            end
            if (o_out_valid && !out_stall) begin
                seen.x    = o_block_x;
                seen.y    = o_block_y;
                seen.tl   = o_top_left;
                seen.tr   = o_top_right;
                seen.bl   = o_bottom_left;
                seen.br   = o_bottom_right;
                seen.fend = o_frame_end;
                sb.check_block(seen);
                any_transfer = 1'b1;
            end
            if (any_transfer) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_scale2x_pixel_upscaler: errors");
                $finish;
            end
        end
    end

    // one pixel transfer, with a random gap in front of it
    task automatic send_pixel(input t_pix p);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= p;
        do @(posedge clk); while (o_in_stall);
    endtask

    // wait for the pipeline to empty
    task automatic drain();
        pix_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // frame size written only between frames with nothing in flight
    task automatic configure(input int unsigned w_raw, input int unsigned h_raw);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_WIDTH;
        cfg_data  <= CFG_DATA_W'(w_raw);
        do @(posedge clk); while (!o_cfg_ready);
        cfg_index <= CFG_IDX_HEIGHT;
        cfg_data  <= CFG_DATA_W'(h_raw);
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // whole frame from a small palette so that neighbours often match
    task automatic random_frame(input int unsigned w_raw, input int unsigned h_raw,
                                output int unsigned sent);
        t_pix        palette [4];
        int unsigned npal;
        t_pix        p;
        configure(w_raw, h_raw);
        npal = $urandom_range(2, 4);
        foreach (palette[i]) begin
            case ($urandom_range(3))
                0:       palette[i] = COL_BLACK;
                1:       palette[i] = COL_WHITE;
                default: palette[i] = t_pix'($urandom);
            endcase
        end
        sent = sb.frame_size();
        for (int unsigned i = 0; i < sent; i++) begin
            if ($urandom_range(9) < 8) p = palette[$urandom_range(npal - 1)];
            else p = t_pix'($urandom);
            send_pixel(p);
        end
    endtask

    // stimulus
    initial begin
        int unsigned random_items;
        int unsigned frame_no;
        int unsigned sent;
        int unsigned w_raw;
        int unsigned h_raw;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames
        configure(3, 3);
        foreach (FRAME_3X3[i]) send_pixel(FRAME_3X3[i]);
        configure(0, 0);
        send_pixel(COL_WHITE);
        configure(4, 2);
        foreach (FRAME_4X2[i]) send_pixel(FRAME_4X2[i]);

        // random frames of small size, cycling through the idling phases
        random_items = 0;
        frame_no     = 0;
        while (random_items < RANDOM_ITEMS) begin
            case (frame_no % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            case ($urandom_range(9))
                0:       w_raw = 0;
                1:       w_raw = 1;
                default: w_raw = $urandom_range(2, 9);
            endcase
            case ($urandom_range(9))
                0:       h_raw = 0;
                1:       h_raw = 1;
                default: h_raw = $urandom_range(2, 6);
            endcase
            random_frame(w_raw, h_raw, sent);
            random_items += sent;
            frame_no++;
        end

        drain();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb_scale2x_pixel_upscaler: clean");
        end else begin
            $display("tb_scale2x_pixel_upscaler: errors");
        end
        $finish;
    end

endmodule
